// ----- design/ara_pkg.sv -----
package ara_pkg;

    // coordinate range of the atlas
    localparam int COORD_BITS = 12;
    localparam int DIM_W      = COORD_BITS + 1;
    localparam int IN_W       = 13;
    localparam int PAD_W      = IN_W + 1;
    localparam int SIZE_W     = 13;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 2;

    localparam int MAX_FREE_RECTS_DEF = 256;

    localparam logic [DIM_W-1:0]  DIM_LIMIT   = DIM_W'(1) << COORD_BITS;
    localparam logic [DIM_W-1:0]  COORD_MAX   = DIM_LIMIT - DIM_W'(1);
    localparam logic [PAD_W-1:0]  SIZE_MAX    = PAD_W'((1 << SIZE_W) - 1);
    localparam logic [DIM_W-1:0]  MIN_SPLIT   = DIM_W'(2);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_PADDING = 2'd2;

    localparam logic [CFG_W-1:0] ATLAS_WIDTH_RST  = 13'd1024;
    localparam logic [CFG_W-1:0] ATLAS_HEIGHT_RST = 13'd1024;
    localparam logic [3:0]       SLOT_PADDING_RST = 4'd1;

    typedef enum logic [1:0] {
        ST_PLACED = 2'd0,
        ST_NOFIT  = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    typedef struct packed {
        logic [IN_W-1:0] image_width;
        logic [IN_W-1:0] image_height;
    } in_item_t;

    typedef struct packed {
        status_t               status;
        logic [COORD_BITS-1:0] place_x;
        logic [COORD_BITS-1:0] place_y;
        logic [SIZE_W-1:0]     padded_width;
        logic [SIZE_W-1:0]     padded_height;
    } out_item_t;

    // one free rectangle
    typedef struct packed {
        logic [DIM_W-1:0] x;
        logic [DIM_W-1:0] y;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
    } rect_t;

    // per-cycle control of the cell row
    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

    // guillotine split of the chosen rectangle
    typedef struct packed {
        logic  need_split;
        rect_t piece_a;
        rect_t piece_b;
    } split_t;

    // padded size fits in the rectangle
    function automatic logic rect_fits(rect_t r, logic [PAD_W-1:0] pw, logic [PAD_W-1:0] ph);
        return (pw <= PAD_W'(r.w)) && (ph <= PAD_W'(r.h));
    endfunction

endpackage

// ----- design/ara_cell.sv -----
module ara_cell
    import ara_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  rect_t      nbr,
    input  rect_t      load_data,
    output rect_t      rect
);

    rect_t rect_reg;
    rect_t rect_next;

    // load a root rectangle, take the neighbor's entry, or hold
    always_comb
    begin
        rect_next = rect_reg;
        if (ctrl.load)
        begin
            rect_next = load_data;
        end
        else if (ctrl.shift)
        begin
            rect_next = nbr;
        end
    end

    always_ff @(posedge clk)
    begin
        rect_reg <= rect_next;
    end

    assign rect = rect_reg;

endmodule

// ----- design/ara_split.sv -----
module ara_split
    import ara_pkg::*;
(
    input  rect_t            f,
    input  logic [PAD_W-1:0] pw,
    input  logic [PAD_W-1:0] ph,
    output split_t           split
);

    logic [DIM_W-1:0] pw_d;
    logic [DIM_W-1:0] ph_d;
    logic [DIM_W-1:0] rw;
    logic [DIM_W-1:0] rh;

    // leftovers, meaningful only when the padded size fits
    always_comb
    begin
        pw_d = pw[DIM_W-1:0];
        ph_d = ph[DIM_W-1:0];
        rw   = f.w - pw_d;
        rh   = f.h - ph_d;
    end

    // cut along the shorter leftover
    always_comb
    begin
        split.need_split = (rw >= MIN_SPLIT) || (rh >= MIN_SPLIT);
        if (rh <= rw)
        begin
            split.piece_a = '{x: f.x,        y: f.y + ph_d, w: pw_d, h: rh};
            split.piece_b = '{x: f.x + pw_d, y: f.y,        w: rw,   h: f.h};
        end
        else
        begin
            split.piece_a = '{x: f.x + pw_d, y: f.y,        w: rw,   h: ph_d};
            split.piece_b = '{x: f.x,        y: f.y + ph_d, w: f.w,  h: rh};
        end
    end

endmodule

// ----- design/atlas_rect_allocator.sv -----
// atlas rectangle allocator, first-fit guillotine packing
//
// in channel: in_valid / in_stall / in_data carry image width and height;
// a transfer happens when in_valid is high and in_stall is low.
// out channel: out_valid / out_stall / out_data carry status, placement
// corner and padded size, one result per request.
// config port: cfg_write with cfg_index and cfg_data writes atlas width,
// atlas height or slot padding; any valid write rebuilds the free list.
// the free list lives in a ring of MAX_FREE_RECTS cells that rotates one
// entry per cycle while a request scans or rewrites it. a request takes one
// rotation to find the first fit and, when placed, a second rotation that
// rewrites the list in order; no fit or a full list skips the second one.
// the next request is taken once the allocator is back in idle, so items go
// one at a time. after reset, and after a config write once the allocator
// is idle, the list is reloaded with one rectangle covering the atlas;
// in_stall stays high until that reload.
// a finished result sits in the output register; a new request is taken
// while it waits, and a stalled receiver holds the next result back.
module atlas_rect_allocator
    import ara_pkg::*;
#(
    parameter int MAX_FREE_RECTS = MAX_FREE_RECTS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int IDX_W = (MAX_FREE_RECTS > 1) ? $clog2(MAX_FREE_RECTS) : 1;
    localparam int CNT_W = $clog2(MAX_FREE_RECTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_FREE_RECTS - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_FREE_RECTS);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_DECIDE = 5'b00100,
        S_BUILD  = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   t_reg, t_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pending_reg, pending_next;
    logic               found_reg, found_next;
    status_t            status_reg, status_next;
    logic               out_valid_reg, out_valid_next;
    logic [CFG_W-1:0]   atlas_w_reg, atlas_h_reg;
    logic [3:0]         pad_reg;

    logic [IDX_W-1:0]   idx_reg, idx_next;
    rect_t              f_reg, f_next;
    logic [PAD_W-1:0]   pw_reg, pw_next;
    logic [PAD_W-1:0]   ph_reg, ph_next;
    rect_t              d1_reg, d2_reg;
    out_item_t          out_data_reg, out_data_next;

    rect_t              cell_q [MAX_FREE_RECTS];
    rect_t              head;
    rect_t              second;
    rect_t              stream;
    rect_t              root;
    cell_ctrl_t         cell_ctrl;
    split_t             split;
    logic               cfg_hit;
    logic               out_free;
    logic [CNT_W-1:0]   t_cnt;
    logic [CNT_W-1:0]   idx_plus1;

    assign head   = cell_q[0];
    assign second = cell_q[1];

    // root rectangle from the configured size, saturated to the coordinate range
    always_comb
    begin
        root.x = '0;
        root.y = '0;
        root.w = (atlas_w_reg > DIM_LIMIT) ? DIM_LIMIT : DIM_W'(atlas_w_reg);
        root.h = (atlas_h_reg > DIM_LIMIT) ? DIM_LIMIT : DIM_W'(atlas_h_reg);
    end

    // split of the chosen rectangle
    ara_split u_split (
        .f     (f_reg),
        .pw    (pw_reg),
        .ph    (ph_reg),
        .split (split)
    );

    // ring of cells, each taking its right neighbor; the last takes the stream
    genvar j;
    generate
        for (j = 0; j < MAX_FREE_RECTS; j++)
        begin : g_cell
            cell_ctrl_t ctrl_j;
            rect_t      nbr_j;
            always_comb
            begin
                ctrl_j.shift = cell_ctrl.shift;
                ctrl_j.load  = cell_ctrl.load && (j == 0);
            end
            if (j == MAX_FREE_RECTS - 1)
            begin : g_tail
                assign nbr_j = stream;
            end
            else
            begin : g_inner
                assign nbr_j = cell_q[j+1];
            end
            ara_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl_j),
                .nbr       (nbr_j),
                .load_data (root),
                .rect      (cell_q[j])
            );
        end
    endgenerate

    // config write decode
    assign cfg_hit = cfg_write && ((cfg_index == CFG_ATLAS_WIDTH) ||
                                   (cfg_index == CFG_ATLAS_HEIGHT) ||
                                   (cfg_index == CFG_SLOT_PADDING));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atlas_w_reg <= ATLAS_WIDTH_RST;
            atlas_h_reg <= ATLAS_HEIGHT_RST;
            pad_reg     <= SLOT_PADDING_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_ATLAS_WIDTH:  atlas_w_reg <= cfg_data;
                CFG_ATLAS_HEIGHT: atlas_h_reg <= cfg_data;
                CFG_SLOT_PADDING: pad_reg     <= cfg_data[3:0];
                default:          ;
            endcase
        end
    end

    // stream into the tail: plain rotation while scanning, rewritten list while building
    assign t_cnt     = CNT_W'(t_reg);
    assign idx_plus1 = CNT_W'(idx_reg) + CNT_W'(1);

    always_comb
    begin
        stream = head;
        if (state_reg == S_BUILD)
        begin
            if (split.need_split)
            begin
                if (t_reg == IDX_W'(0))
                begin
                    stream = split.piece_a;
                end
                else if (t_reg == IDX_W'(1))
                begin
                    stream = split.piece_b;
                end
                else if (t_cnt <= idx_plus1)
                begin
                    stream = d2_reg;
                end
                else
                begin
                    stream = d1_reg;
                end
            end
            else if (t_reg >= idx_reg)
            begin
                stream = second;
            end
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    // request sequencer
    always_comb
    begin
        state_next      = state_reg;
        t_next          = t_reg;
        count_next      = count_reg;
        pending_next    = pending_reg;
        found_next      = found_reg;
        status_next     = status_reg;
        idx_next        = idx_reg;
        f_next          = f_reg;
        pw_next         = pw_reg;
        ph_next         = ph_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg && out_stall;
        cell_ctrl.shift = (state_reg == S_SCAN) || (state_reg == S_BUILD);
        cell_ctrl.load  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (pending_reg)
                begin
                    cell_ctrl.load = 1'b1;
                    count_next     = CNT_W'(1);
                    pending_next   = 1'b0;
                end
                else if (in_valid)
                begin
                    pw_next    = PAD_W'(in_data.image_width) + PAD_W'({pad_reg, 1'b0});
                    ph_next    = PAD_W'(in_data.image_height) + PAD_W'({pad_reg, 1'b0});
                    t_next     = '0;
                    found_next = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!found_reg && (t_cnt < count_reg) && rect_fits(head, pw_reg, ph_reg))
                begin
                    found_next = 1'b1;
                    idx_next   = t_reg;
                    f_next     = head;
                end
                t_next = t_reg + IDX_W'(1);
                if (t_reg == LAST_IDX)
                begin
                    t_next     = '0;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                t_next = '0;
                if (!found_reg)
                begin
                    status_next = ST_NOFIT;
                    state_next  = S_DONE;
                end
                else if (split.need_split && (count_reg == FULL_CNT))
                begin
                    status_next = ST_FULL;
                    state_next  = S_DONE;
                end
                else
                begin
                    status_next = ST_PLACED;
                    state_next  = S_BUILD;
                end
            end
            S_BUILD:
            begin
                t_next = t_reg + IDX_W'(1);
                if (t_reg == LAST_IDX)
                begin
                    t_next     = '0;
                    count_next = split.need_split ? count_reg + CNT_W'(1)
                                                  : count_reg - CNT_W'(1);
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_data_next.status        = status_reg;
                    out_data_next.place_x       = '0;
                    out_data_next.place_y       = '0;
                    if (status_reg == ST_PLACED)
                    begin
                        out_data_next.place_x = (f_reg.x > COORD_MAX) ? COORD_MAX[COORD_BITS-1:0]
                                                                      : f_reg.x[COORD_BITS-1:0];
                        out_data_next.place_y = (f_reg.y > COORD_MAX) ? COORD_MAX[COORD_BITS-1:0]
                                                                      : f_reg.y[COORD_BITS-1:0];
                    end
                    out_data_next.padded_width  = (pw_reg > SIZE_MAX) ? SIZE_MAX[SIZE_W-1:0]
                                                                      : pw_reg[SIZE_W-1:0];
                    out_data_next.padded_height = (ph_reg > SIZE_MAX) ? SIZE_MAX[SIZE_W-1:0]
                                                                      : ph_reg[SIZE_W-1:0];
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // any valid config write rebuilds the list
        if (cfg_hit)
        begin
            pending_next = 1'b1;
            count_next   = CNT_W'(1);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            t_reg         <= '0;
            count_reg     <= CNT_W'(1);
            pending_reg   <= 1'b1;
            found_reg     <= 1'b0;
            status_reg    <= ST_NOFIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            t_reg         <= t_next;
            count_reg     <= count_next;
            pending_reg   <= pending_next;
            found_reg     <= found_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, with a two-entry delay line of the head for the split rewrite
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        f_reg        <= f_next;
        pw_reg       <= pw_next;
        ph_reg       <= ph_next;
        d1_reg       <= head;
        d2_reg       <= d1_reg;
        out_data_reg <= out_data_next;
    end

    assign in_stall  = (state_reg != S_IDLE) || pending_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
